/* rtl/core/sbsh_pkg.sv */
package sbsh_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned COUNT_W   = 61;
    localparam int unsigned ROUNDS    = 80;
    localparam int unsigned ROUND_W   = 7;
    localparam int unsigned BLK_WORDS = 16;

    localparam logic [WORD_W-1:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;
    localparam logic [7:0]        PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_MSG,
        PH_PAD1,
        PH_FINAL
    } phase_t;

    typedef struct packed {
        logic accept;     // input request taken this edge
        logic start;      // load working vars from chain words
        logic round_en;   // run one compression round
        logic add;        // fold working vars into chain words
        logic pad;        // write 0x80 and zero the tail of the block
        logic len_write;  // write the bit length into the last two words
        logic len_clear;  // zero the first fourteen words with the length
        logic out_load;   // capture digest and restart the message
    } cmd_t;

    typedef struct packed {
        logic fill_full;  // accepted byte completes a block
        logic last_in;    // request ends the message
        logic pos_hi;     // fill position leaves no room for the length
        logic round_last; // final round of the block
        logic out_free;   // result register can take a digest
    } stat_t;

endpackage

/* rtl/core/sbsh_ctrl.sv */
module sbsh_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sbsh_pkg::stat_t st,
    output sbsh_pkg::cmd_t  cmd
);
    import sbsh_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   last_pend_reg, last_pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MSG;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            last_pend_reg <= last_pend_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        last_pend_next = last_pend_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    if (st.fill_full) begin
                        phase_next     = PH_MSG;
                        last_pend_next = st.last_in;
                        state_next     = ST_START;
                    end else if (st.last_in) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (st.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.add = 1'b1;
                case (phase_reg)
                    PH_MSG: begin
                        state_next     = last_pend_reg ? ST_PAD : ST_IDLE;
                        last_pend_next = 1'b0;
                    end
                    PH_PAD1:  state_next = ST_LEN;
                    PH_FINAL: state_next = ST_OUT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_PAD: begin
                cmd.pad = 1'b1;
                if (st.pos_hi) begin
                    phase_next = PH_PAD1;
                    state_next = ST_START;
                end else begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                cmd.len_write = 1'b1;
                cmd.len_clear = (phase_reg == PH_PAD1);
                phase_next    = PH_FINAL;
                state_next    = ST_START;
            end
            ST_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    phase_next   = PH_MSG;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/core/sbsh_datapath.sv */
module sbsh_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sbsh_pkg::cmd_t                cmd,
    output sbsh_pkg::stat_t               st,
    input  logic [7:0]                    msg_byte,
    input  logic                          has_byte,
    input  logic                          last_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbsh_pkg::WORD_W-1:0]   hash_word [5],
    output logic                          length_error
);
    import sbsh_pkg::*;

    logic [WORD_W-1:0]  w_reg     [BLK_WORDS];
    logic [WORD_W-1:0]  w_next    [BLK_WORDS];
    logic [WORD_W-1:0]  chain_reg [5];
    logic [WORD_W-1:0]  var_reg   [5];
    logic [WORD_W-1:0]  hash_reg  [5];
    logic [COUNT_W-1:0] count_reg;
    logic               ovf_reg;
    logic [ROUND_W-1:0] round_reg;
    logic               m_valid_reg;
    logic               err_reg;

    logic               sat;
    logic               take_byte;
    logic [5:0]         pos;
    logic [WORD_W-1:0]  f_val, k_val, t_val, w_new;
    logic [4:0]         lane_sh;

    assign sat       = &count_reg;
    assign pos       = count_reg[5:0];
    assign take_byte = cmd.accept && has_byte && !sat;
    assign lane_sh   = {~pos[1:0], 3'b000};

    assign st.fill_full  = has_byte && !sat && (pos == 6'h3F);
    assign st.last_in    = last_item;
    assign st.pos_hi     = (pos >= 6'd56);
    assign st.round_last = (round_reg == ROUND_W'(ROUNDS - 1));
    assign st.out_free   = !m_valid_reg || m_ready;

    // round function and constant by round range
    always_comb begin
        if (round_reg < ROUND_W'(20)) begin
            f_val = (var_reg[1] & var_reg[2]) | (~var_reg[1] & var_reg[3]);
            k_val = K_0;
        end else if (round_reg < ROUND_W'(40)) begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K_1;
        end else if (round_reg < ROUND_W'(60)) begin
            f_val = (var_reg[1] & var_reg[2]) | (var_reg[1] & var_reg[3])
                  | (var_reg[2] & var_reg[3]);
            k_val = K_2;
        end else begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K_3;
        end
        t_val = {var_reg[0][26:0], var_reg[0][31:27]} + f_val + var_reg[4]
              + k_val + w_reg[0];
    end

    assign w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];

    always_comb begin
        w_next = w_reg;
        if (take_byte) begin
            w_next[pos[5:2]][lane_sh +: 8] = msg_byte;
        end
        if (cmd.round_en) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                w_next[i] = w_reg[i+1];
            end
            w_next[BLK_WORDS-1] = {w_new[30:0], w_new[31]};
        end
        if (cmd.pad) begin
            for (int i = 0; i < BLK_WORDS; i++) begin
                for (int j = 0; j < 4; j++) begin
                    if (6'(4 * i + j) == pos) begin
                        w_next[i][8*(3-j) +: 8] = PAD_BYTE;
                    end else if (6'(4 * i + j) > pos) begin
                        w_next[i][8*(3-j) +: 8] = 8'h00;
                    end
                end
            end
        end
        if (cmd.len_write) begin
            if (cmd.len_clear) begin
                for (int i = 0; i < BLK_WORDS - 2; i++) begin
                    w_next[i] = '0;
                end
            end
            w_next[BLK_WORDS-2] = count_reg[COUNT_W-1:29];
            w_next[BLK_WORDS-1] = {count_reg[28:0], 3'b000};
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        if (cmd.start) begin
            var_reg <= chain_reg;
        end else if (cmd.round_en) begin
            var_reg[0] <= t_val;
            var_reg[1] <= var_reg[0];
            var_reg[2] <= {var_reg[1][1:0], var_reg[1][31:2]};
            var_reg[3] <= var_reg[2];
            var_reg[4] <= var_reg[3];
        end
        if (cmd.out_load) begin
            hash_reg <= chain_reg;
            err_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg   <= H_INIT;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                round_reg <= '0;
            end else if (cmd.round_en) begin
                round_reg <= round_reg + ROUND_W'(1);
            end
            if (cmd.out_load) begin
                chain_reg <= H_INIT;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                if (cmd.add) begin
                    for (int i = 0; i < 5; i++) begin
                        chain_reg[i] <= chain_reg[i] + var_reg[i];
                    end
                end
                if (take_byte) begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
                if (cmd.accept && has_byte && sat) begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign hash_word    = hash_reg;
    assign length_error = err_reg;

endmodule

/* rtl/core/sha1_byte_stream_hash.sv */
// sha-1 of a byte stream: one byte per request, digest on the last request
// a byte request that neither fills a block nor ends the message leaves input ready; a byte that fills
// a block holds off input while the block runs (load, 80 rounds, chain add)
// the last request adds padding and compression (two blocks when the length
// spills into a second block), then a load into the result register, held while full
// aresetn is synchronous, active low: chain words, counters and control clear
module sha1_byte_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    // byte requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_msg_byte,
    input  logic        s_has_byte,
    input  logic        s_last_item,
    // digest results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_word_0,
    output logic [31:0] m_hash_word_1,
    output logic [31:0] m_hash_word_2,
    output logic [31:0] m_hash_word_3,
    output logic [31:0] m_hash_word_4,
    output logic        m_length_error
);
    import sbsh_pkg::*;

    cmd_t              cmd;
    stat_t             st;
    logic [WORD_W-1:0] hash_word [5];

    // sequencer: request intake, block runs, padding and digest hand-off
    sbsh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // block buffer, schedule window, round unit, chain words, result register
    sbsh_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .st           (st),
        .msg_byte     (s_msg_byte),
        .has_byte     (s_has_byte),
        .last_item    (s_last_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .hash_word    (hash_word),
        .length_error (m_length_error)
    );

    // digest words, most significant first
    assign m_hash_word_0 = hash_word[0];
    assign m_hash_word_1 = hash_word[1];
    assign m_hash_word_2 = hash_word[2];
    assign m_hash_word_3 = hash_word[3];
    assign m_hash_word_4 = hash_word[4];

endmodule

/* tb/sha1_byte_stream_hash_tb.sv */
`timescale 1ns / 100ps

module sha1_byte_stream_hash_tb;

    localparam int unsigned ITEM_TARGET   = 550;
    localparam int unsigned MSG_TARGET    = 40;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned SETTLE_CYCLES = 200;   // longer than the last-request latency
    localparam int unsigned CYCLE_LIMIT   = 250000;
    localparam int unsigned MAX_REPORTS   = 10;

    // sha-1 constants
    localparam logic [31:0] IV_0   = 32'h67452301;
    localparam logic [31:0] IV_1   = 32'hEFCDAB89;
    localparam logic [31:0] IV_2   = 32'h98BADCFE;
    localparam logic [31:0] IV_3   = 32'h10325476;
    localparam logic [31:0] IV_4   = 32'hC3D2E1F0;
    localparam logic [31:0] KR_0   = 32'h5A827999;
    localparam logic [31:0] KR_1   = 32'h6ED9EBA1;
    localparam logic [31:0] KR_2   = 32'h8F1BBCDC;
    localparam logic [31:0] KR_3   = 32'hCA62C1D6;
    localparam logic [7:0]  MARKER = 8'h80;
    localparam logic [60:0] LEN_SAT = '1;

    // one byte request as the driver presents it
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       last_item;
        logic       drain;      // wait for every digest before offering this one
    } byte_req_t;

    typedef struct packed {
        logic [4:0][31:0] words;
        logic             len_err;
    } digest_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_msg_byte = '0;
    logic        s_has_byte = 1'b0;
    logic        s_last_item = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_hash_word_0;
    logic [31:0] m_hash_word_1;
    logic [31:0] m_hash_word_2;
    logic [31:0] m_hash_word_3;
    logic [31:0] m_hash_word_4;
    logic        m_length_error;

    sha1_byte_stream_hash DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_msg_byte     (s_msg_byte),
        .s_has_byte     (s_has_byte),
        .s_last_item    (s_last_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_word_0  (m_hash_word_0),
        .m_hash_word_1  (m_hash_word_1),
        .m_hash_word_2  (m_hash_word_2),
        .m_hash_word_3  (m_hash_word_3),
        .m_hash_word_4  (m_hash_word_4),
        .m_length_error (m_length_error)
    );

    // pending requests and the digests they are expected to produce
    byte_req_t req_q[$];
    digest_t   digest_q[$];

    // predictor state: chaining words, the block being filled, byte count
    logic [31:0] chain_h [5];
    logic [7:0]  blk [64];
    logic [60:0] nbytes;
    logic        len_ovf;

    int unsigned requests_queued = 0;
    int unsigned requests_taken  = 0;
    int unsigned counted_items   = 0;
    int unsigned messages_queued = 0;
    int unsigned digests_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned longest_msg     = 0;
    int unsigned cycle_cnt       = 0;

    logic        in_fire = 1'b0;
    byte_req_t   nxt;
    digest_t     got;
    digest_t     want;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    logic [15:0] ready_pat  = '1;
    int unsigned pat_age    = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // 80-round compression of blk into the chaining words
    function automatic void compress_chunk();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 80; r++) begin
            x    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {x[30:0], x[31]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = KR_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = KR_1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = KR_2;
            end else begin
                f = b ^ c ^ d;
                k = KR_3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void restart_message();
        chain_h[0] = IV_0;
        chain_h[1] = IV_1;
        chain_h[2] = IV_2;
        chain_h[3] = IV_3;
        chain_h[4] = IV_4;
        nbytes     = '0;
        len_ovf    = 1'b0;
    endfunction

    // fold one accepted request into the running hash, push a digest on the last one
    function automatic void absorb_request(logic [7:0] b, logic has, logic last);
        int unsigned pos;
        logic [63:0] bitlen;
        digest_t     d;
        if (has) begin
            if (nbytes == LEN_SAT) begin
                len_ovf = 1'b1;
            end else begin
                blk[nbytes[5:0]] = b;
                nbytes++;
                if (nbytes[5:0] == 6'd0)
                    compress_chunk();
            end
        end
        if (last) begin
            pos      = 32'(nbytes[5:0]);
            blk[pos] = MARKER;
            for (int i = pos + 1; i < 64; i++)
                blk[i] = 8'h00;
            // no room for the length: it goes into a block of its own
            if (pos >= 56) begin
                compress_chunk();
                for (int i = 0; i < 64; i++)
                    blk[i] = 8'h00;
            end
            bitlen = {nbytes, 3'b000};
            for (int i = 0; i < 8; i++)
                blk[56+i] = bitlen[63-8*i -: 8];
            compress_chunk();
            for (int i = 0; i < 5; i++)
                d.words[i] = chain_h[i];
            d.len_err = len_ovf;
            digest_q.push_back(d);
            restart_message();
        end
    endfunction

    function automatic void log_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("digest %0d: %s expected %08h, got %08h",
                     digests_checked, field, exp_v, act_v);
    endfunction

    function automatic void queue_req(logic [7:0] b, logic has, logic last, logic drain);
        byte_req_t r;
        r.msg_byte  = b;
        r.has_byte  = has;
        r.last_item = last;
        r.drain     = drain;
        req_q.push_back(r);
        requests_queued++;
        counted_items++;
        if (last)
            messages_queued++;
    endfunction

    // biased toward the byte extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one well-formed message with idle requests sprinkled between the bytes
    function automatic void queue_message(int unsigned len, bit marker_end, bit drain);
        bit first;
        first = drain;
        if (len == 0)
            marker_end = 1'b1;
        if (len > longest_msg)
            longest_msg = len;
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, first);
                first = 1'b0;
            end
            queue_req(pick_byte(), 1'b1, (i == len - 1) && !marker_end, first);
            first = 1'b0;
        end
        if (marker_end)
            queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, first);
    endfunction

    // stimulus, reset and end of run
    initial begin
        int unsigned rnd_msg;
        int unsigned len;
        restart_message();
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;

        // directed: empty message, idle request, one-byte extremes, "abc", a message
        // closed by an empty end marker, then an idle request and another empty message
        queue_req(8'h00, 1'b0, 1'b1, 1'b0);
        queue_req(8'hFF, 1'b0, 1'b0, 1'b0);
        queue_req(8'h00, 1'b1, 1'b1, 1'b0);
        queue_req(8'hFF, 1'b1, 1'b1, 1'b0);
        queue_req(8'h61, 1'b1, 1'b0, 1'b0);
        queue_req(8'h62, 1'b1, 1'b0, 1'b0);
        queue_req(8'h63, 1'b1, 1'b1, 1'b0);
        queue_req(8'h61, 1'b1, 1'b0, 1'b0);
        queue_req(8'h62, 1'b1, 1'b0, 1'b0);
        queue_req(8'hA5, 1'b0, 1'b1, 1'b0);
        queue_req(8'h5A, 1'b0, 1'b0, 1'b0);
        queue_req(8'hFF, 1'b0, 1'b1, 1'b0);
        longest_msg = 3;

        // random messages: mostly short, some right at the padding boundaries
        rnd_msg = 0;
        while (counted_items < ITEM_TARGET || messages_queued < MSG_TARGET) begin
            case ($urandom_range(0, 9))
                7, 8: len = $urandom_range(9, 30);
                9: begin
                    case ($urandom_range(0, 8))
                        0: len = 55;
                        1: len = 56;
                        2: len = 57;
                        3: len = 63;
                        4: len = 64;
                        5: len = 65;
                        6: len = 119;
                        7: len = 120;
                        default: len = 128;
                    endcase
                end
                default: len = $urandom_range(0, 8);
            endcase
            // two pauses where the sender waits for every digest first
            queue_message(len, $urandom_range(0, 3) == 0, rnd_msg == 0 || rnd_msg == 25);
            rnd_msg++;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (requests_taken < requests_queued)
            @(negedge aclk);
        while (digest_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("run covered %0d requests in %0d messages (longest %0d bytes)",
                 requests_taken, messages_queued, longest_msg);
        $display("%0d digests compared, %0d field mismatches", digests_checked, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // sender: bursts of random length with random gaps, holds a request until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (gap_left != 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (req_q.size() == 0 || (req_q[0].drain && digest_q.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                nxt = req_q.pop_front();
                s_msg_byte  <= nxt.msg_byte;
                s_has_byte  <= nxt.has_byte;
                s_last_item <= nxt.last_item;
                s_valid     <= 1'b1;
                if (burst_left <= 1) begin
                    // now and then a long burst with no idling at all
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left <= $urandom_range(40, 80);
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= $urandom_range(1, 8);
                    end
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: rotating ready pattern, renewed each time its age counter wraps, plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && digests_checked >= 6) begin
            // stall the result side long enough for the block to back up its input
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ready_pat[0];
            if (pat_age == 63) begin
                pat_age <= 0;
                case ($urandom_range(0, 3))
                    0: ready_pat <= '1;
                    1: ready_pat <= 16'($urandom | $urandom);
                    2: ready_pat <= 16'($urandom);
                    default: ready_pat <= 16'(($urandom & $urandom) | 32'h0000_0001);
                endcase
            end else begin
                pat_age   <= pat_age + 1;
                ready_pat <= {ready_pat[0], ready_pat[15:1]};
            end
        end
    end

    // monitor: predict on every accepted request, compare every accepted digest
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                requests_taken++;
                absorb_request(s_msg_byte, s_has_byte, s_last_item);
            end
            if (m_valid && m_ready) begin
                got.words[0] = m_hash_word_0;
                got.words[1] = m_hash_word_1;
                got.words[2] = m_hash_word_2;
                got.words[3] = m_hash_word_3;
                got.words[4] = m_hash_word_4;
                got.len_err  = m_length_error;
                if (digest_q.size() == 0) begin
                    log_mismatch("unexpected digest, word 0", 32'h0, got.words[0]);
                end else begin
                    want = digest_q.pop_front();
                    for (int i = 0; i < 5; i++)
                        if (got.words[i] !== want.words[i])
                            log_mismatch($sformatf("hash_word_%0d", i),
                                         want.words[i], got.words[i]);
                    if (got.len_err !== want.len_err)
                        log_mismatch("length_error", 32'(want.len_err), 32'(got.len_err));
                end
                digests_checked++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digests outstanding",
                     cycle_cnt, digest_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
